// ----- sv/assert_macros.svh -----
// assertion macros for the uv placement transform
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UVP_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("uvp assertion failed");
`define UVP_ASSERT_NR(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("uvp assertion failed");
`else
`define UVP_ASSERT(lbl, prop)
`define UVP_ASSERT_NR(lbl, prop)
`endif
`endif

// ----- sv/uvp_pkg.sv -----
// package for the uv placement transform: types, register codes, saturation
// no dependencies
package uvp_pkg;

  typedef enum logic [2:0] {
    REG_COVERAGE  = 3'd0,
    REG_TRANSLATE = 3'd1,
    REG_FRAME_ROT = 3'd2,
    REG_REPEAT    = 3'd3,
    REG_OFFSET    = 3'd4,
    REG_UV_ROT    = 3'd5,
    REG_MODE      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] coverage;
    logic [63:0] translate;
    logic [63:0] frame_rot;
    logic [63:0] rep;
    logic [63:0] offset;
    logic [63:0] uv_rot;
    logic [4:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic oof;
  } meta_t;

  localparam int MODE_MIR_U = 0;
  localparam int MODE_MIR_V = 1;
  localparam int MODE_WRAP_U = 2;
  localparam int MODE_STAGGER = 4;

  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    if (x > SAT_HI) return SAT_MAX;
    else if (x < SAT_LO) return SAT_MIN;
    else return $signed(x[31:0]);
  endfunction

endpackage

// ----- sv/uvp_if.sv -----
// channel interfaces of the uv placement transform
// no dependencies
interface uvp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] u_in;
  logic signed [31:0] v_in;
  modport source(output valid, u_in, v_in, input ready);
  modport sink(input valid, u_in, v_in, output ready);
endinterface

interface uvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] u_out;
  logic signed [31:0] v_out;
  logic               out_of_frame;
  modport source(output valid, u_out, v_out, out_of_frame, input ready);
  modport sink(input valid, u_out, v_out, out_of_frame, output ready);
endinterface

interface uvp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/uv_placement_transform.sv -----
// the divider takes 31 + FRACTION_BITS stages
// throughput one transaction per cycle; the whole pipeline stalls while a result waits
// synchronous active-low reset clears the valid bits and loads the register defaults
// top level of the uv placement transform; depends on uvp_pkg, uvp_if and all uvp modules
`include "assert_macros.svh"
module uv_placement_transform #(
  parameter int FRACTION_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  uvp_in_if.sink     in_ch,
  uvp_out_if.source  out_ch,
  uvp_cfg_if.sink    cfg_ch
);
  import uvp_pkg::*;

  localparam int NW = 31 + FRACTION_BITS;

  cfg_t               cfg;
  logic               en;
  meta_t              meta_in, meta_f, meta_d, meta_b;
  logic [1:0][NW-1:0] num;
  logic [1:0]         neg;
  logic [1:0][30:0]   dvs;
  logic [1:0][31:0]   q;
  logic signed [31:0] bu, bv;
  logic               out_valid_r, oof_r;
  logic signed [31:0] u_out_r, v_out_r;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign meta_in = '{vld: in_ch.valid, oof: 1'b0};
  assign dvs[0] = cfg.coverage[30:0];
  assign dvs[1] = cfg.coverage[62:32];

  uvp_cfg_regs #(.F(FRACTION_BITS)) u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .cfg(cfg)
  );

  uvp_front #(.F(FRACTION_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg), .meta_i(meta_in),
    .u_i(in_ch.u_in), .v_i(in_ch.v_in), .meta_o(meta_f), .num_o(num), .neg_o(neg)
  );

  uvp_div #(.F(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .meta_i(meta_f), .num_i(num), .neg_i(neg),
    .dvs_i(dvs), .meta_o(meta_d), .q_o(q)
  );

  uvp_back #(.F(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg), .meta_i(meta_d), .q_i(q),
    .meta_o(meta_b), .u_o(bu), .v_o(bv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= meta_b.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oof_r   <= meta_b.oof;
      u_out_r <= meta_b.oof ? SAT_MIN : bu;
      v_out_r <= meta_b.oof ? SAT_MIN : bv;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.u_out = u_out_r;
  assign out_ch.v_out = v_out_r;
  assign out_ch.out_of_frame = oof_r;

  `UVP_ASSERT_NR(a_reset_clears, !rst_n |=> !out_ch.valid)
  `UVP_ASSERT(a_stall_keeps, out_ch.valid && !out_ch.ready |=> out_ch.valid)
  `UVP_ASSERT(a_stall_data, out_ch.valid && !out_ch.ready |=> $stable(out_ch.u_out))
  `UVP_ASSERT(a_oof_min, out_ch.valid && out_ch.out_of_frame |-> out_ch.u_out == SAT_MIN && out_ch.v_out == SAT_MIN)
endmodule

// ----- sv/uvp_cfg_regs.sv -----
// configuration register file of the uv placement transform
// depends on uvp_pkg and uvp_if
module uvp_cfg_regs #(
  parameter int F = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  uvp_cfg_if.sink       cfg_ch,
  output uvp_pkg::cfg_t cfg
);
  import uvp_pkg::*;

  localparam logic [31:0] ONE = 32'd1 << F;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coverage  <= {ONE, ONE};
      cfg_r.translate <= '0;
      cfg_r.frame_rot <= {32'd0, ONE};
      cfg_r.rep       <= {ONE, ONE};
      cfg_r.offset    <= '0;
      cfg_r.uv_rot    <= {32'd0, ONE};
      cfg_r.mode      <= 5'd12;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_COVERAGE:  cfg_r.coverage  <= cfg_ch.data;
        REG_TRANSLATE: cfg_r.translate <= cfg_ch.data;
        REG_FRAME_ROT: cfg_r.frame_rot <= cfg_ch.data;
        REG_REPEAT:    cfg_r.rep       <= cfg_ch.data;
        REG_OFFSET:    cfg_r.offset    <= cfg_ch.data;
        REG_UV_ROT:    cfg_r.uv_rot    <= cfg_ch.data;
        REG_MODE:      cfg_r.mode      <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/uvp_rotate.sv -----
// two stage rotation about (0.5, 0.5): products, then floored sum and saturation
// depends on uvp_pkg
module uvp_rotate #(
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [63:0]         cs,
  input  uvp_pkg::meta_t      meta_i,
  input  logic signed [31:0]  u_i,
  input  logic signed [31:0]  v_i,
  output uvp_pkg::meta_t      meta_o,
  output logic signed [31:0]  u_o,
  output logic signed [31:0]  v_o
);
  import uvp_pkg::*;

  localparam logic signed [32:0] HALF = 33'sd1 <<< (F - 1);
  localparam logic signed [71:0] HALF_W = 72'sd1 <<< (F - 1);

  logic signed [31:0] c, s;
  logic signed [32:0] x, y;
  logic signed [64:0] pcx_r, psy_r, pcy_r, psx_r;
  meta_t              meta_a_r, meta_b_r;
  logic signed [31:0] u_r, v_r;

  assign c = $signed(cs[31:0]);
  assign s = $signed(cs[63:32]);
  assign x = 33'(u_i) - HALF;
  assign y = 33'(v_i) - HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_a_r <= '0;
      meta_b_r <= '0;
    end else if (en) begin
      meta_a_r <= meta_i;
      meta_b_r <= meta_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcx_r <= 65'(c) * 65'(x);
      psy_r <= 65'(s) * 65'(y);
      pcy_r <= 65'(c) * 65'(y);
      psx_r <= 65'(s) * 65'(x);
      u_r   <= sat32(HALF_W + 72'(pcx_r >>> F) - 72'(psy_r >>> F));
      v_r   <= sat32(HALF_W + 72'(pcy_r >>> F) + 72'(psx_r >>> F));
    end
  end

  assign meta_o = meta_b_r;
  assign u_o = u_r;
  assign v_o = v_r;
endmodule

// ----- sv/uvp_front.sv -----
// front end: frame rotation, translation, frame test, wrap and divider operands
// depends on uvp_pkg and uvp_rotate
module uvp_front #(
  parameter  int F = 16,
  localparam int NW = 31 + F
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  uvp_pkg::cfg_t         cfg,
  input  uvp_pkg::meta_t        meta_i,
  input  logic signed [31:0]    u_i,
  input  logic signed [31:0]    v_i,
  output uvp_pkg::meta_t        meta_o,
  output logic [1:0][NW-1:0]    num_o,
  output logic [1:0]            neg_o
);
  import uvp_pkg::*;

  localparam logic signed [31:0] ONE = 32'sd1 <<< F;
  localparam logic [31:0] FMASK = (32'd1 << F) - 32'd1;

  meta_t              meta_rot, meta_t_r, meta_w_r;
  logic signed [31:0] ru, rv;
  logic signed [31:0] rin [2];
  logic signed [31:0] t_r [2];
  logic [1:0][NW-1:0] num_r;
  logic [1:0]         neg_r;
  logic [1:0]         bad;

  uvp_rotate #(.F(F)) u_rot (
    .clk(clk), .rst_n(rst_n), .en(en), .cs(cfg.frame_rot),
    .meta_i(meta_i), .u_i(u_i), .v_i(v_i),
    .meta_o(meta_rot), .u_o(ru), .v_o(rv)
  );

  assign rin[0] = ru;
  assign rin[1] = rv;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [31:0] cov, tr, frac, w, wm;
    assign cov  = $signed(cfg.coverage[32*l +: 32]);
    assign tr   = $signed(cfg.translate[32*l +: 32]);
    assign frac = $signed(t_r[l] & FMASK);
    assign bad[l] = (frac > cov) || (cov == 32'sd0) ||
                    (!cfg.mode[MODE_WRAP_U + l] && (t_r[l][31] || t_r[l] > ONE));
    assign w  = (cov < ONE) ? frac : t_r[l];
    assign wm = w[31] ? ~w : w;

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[l]   <= sat32(72'(rin[l]) - 72'(tr));
        num_r[l] <= {wm[30:0], {F{w[31]}}};
        neg_r[l] <= w[31];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_t_r <= '0;
      meta_w_r <= '0;
    end else if (en) begin
      meta_t_r <= meta_rot;
      meta_w_r.vld <= meta_t_r.vld;
      meta_w_r.oof <= |bad;
    end
  end

  assign meta_o = meta_w_r;
  assign num_o = num_r;
  assign neg_o = neg_r;
endmodule

// ----- sv/uvp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes
// floor quotient of a signed numerator by a positive divisor, saturated
// depends on uvp_pkg
module uvp_div #(
  parameter  int F = 16,
  localparam int NW = 31 + F
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  uvp_pkg::meta_t      meta_i,
  input  logic [1:0][NW-1:0]  num_i,
  input  logic [1:0]          neg_i,
  input  logic [1:0][30:0]    dvs_i,
  output uvp_pkg::meta_t      meta_o,
  output logic [1:0][31:0]    q_o
);
  import uvp_pkg::*;

  logic [NW-1:0] num_r [2][NW];
  logic [NW-1:0] quo_r [2][NW];
  logic [30:0]   rem_r [2][NW];
  logic          neg_r [2][NW];
  meta_t         meta_r [NW];
  meta_t         meta_q_r;
  logic [1:0][31:0] q_r;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) meta_r[k] <= '0;
        else if (en) meta_r[k] <= meta_i;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) meta_r[k] <= '0;
        else if (en) meta_r[k] <= meta_r[k-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NW-1:0] num_p, quo_p;
      logic [30:0]   rem_p;
      logic          neg_p, ge;
      logic [31:0]   trial;

      if (k == 0) begin : g_src0
        assign num_p = num_i[l];
        assign quo_p = '0;
        assign rem_p = '0;
        assign neg_p = neg_i[l];
      end else begin : g_srcn
        assign num_p = num_r[l][k-1];
        assign quo_p = quo_r[l][k-1];
        assign rem_p = rem_r[l][k-1];
        assign neg_p = neg_r[l][k-1];
      end

      assign trial = {rem_p, num_p[NW-1]};
      assign ge = trial >= {1'b0, dvs_i[l]};

      always_ff @(posedge clk) begin
        if (en) begin
          num_r[l][k] <= num_p << 1;
          quo_r[l][k] <= {quo_p[NW-2:0], ge};
          rem_r[l][k] <= ge ? 31'(trial - {1'b0, dvs_i[l]}) : trial[30:0];
          neg_r[l][k] <= neg_p;
        end
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_out
    logic [NW-1:0] ql;
    logic [31:0]   mag;
    logic          ovf, ng;
    assign ql  = quo_r[l][NW-1];
    assign ng  = neg_r[l][NW-1];
    assign ovf = |ql[NW-1:31];
    assign mag = {1'b0, ql[30:0]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (ovf) q_r[l] <= ng ? SAT_MIN : SAT_MAX;
        else q_r[l] <= ng ? ~mag : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) meta_q_r <= '0;
    else if (en) meta_q_r <= meta_r[NW-1];
  end

  assign meta_o = meta_q_r;
  assign q_o = q_r;
endmodule

// ----- sv/uvp_back.sv -----
// back end: repeat, offset, stagger, mirrors and final rotation
// depends on uvp_pkg and uvp_rotate
module uvp_back #(
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  uvp_pkg::cfg_t       cfg,
  input  uvp_pkg::meta_t      meta_i,
  input  logic [1:0][31:0]    q_i,
  output uvp_pkg::meta_t      meta_o,
  output logic signed [31:0]  u_o,
  output logic signed [31:0]  v_o
);
  import uvp_pkg::*;

  localparam logic signed [71:0] ONE_W = 72'sd1 <<< F;
  localparam logic signed [71:0] HALF_W = 72'sd1 <<< (F - 1);

  meta_t              meta_r_r, meta_o_r, meta_m1_r, meta_m2_r;
  logic signed [63:0] pu_r, pv_r;
  logic signed [31:0] ou_r, ov_r, u1_r, v1_r, u2_r, v2_r;
  logic signed [31:0] au, av, fu1, fv, mu1, mv;
  logic               odd;

  function automatic logic signed [31:0] mirror(input logic signed [31:0] x,
                                                input logic signed [31:0] fl);
    return sat32(72'(fl) + 72'(fl) + ONE_W - 72'(x));
  endfunction

  assign au = sat32(72'(pu_r >>> F));
  assign av = sat32(72'(pv_r >>> F));
  assign odd = ov_r[F];
  assign fv  = {ov_r[31:F], {F{1'b0}}};
  assign mv  = mirror(ov_r, fv);
  assign fu1 = {u1_r[31:F], {F{1'b0}}};
  assign mu1 = mirror(u1_r, fu1);

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r <= 64'($signed(q_i[0])) * 64'($signed(cfg.rep[31:0]));
      pv_r <= 64'($signed(q_i[1])) * 64'($signed(cfg.rep[63:32]));
      ou_r <= sat32(72'(au) + 72'($signed(cfg.offset[31:0])));
      ov_r <= sat32(72'(av) + 72'($signed(cfg.offset[63:32])));
      u1_r <= (odd && cfg.mode[MODE_STAGGER]) ? sat32(72'(ou_r) + HALF_W) : ou_r;
      v1_r <= (odd && cfg.mode[MODE_MIR_V]) ? mv : ov_r;
      u2_r <= (cfg.mode[MODE_MIR_U] && u1_r[F]) ? mu1 : u1_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r_r  <= '0;
      meta_o_r  <= '0;
      meta_m1_r <= '0;
      meta_m2_r <= '0;
    end else if (en) begin
      meta_r_r  <= meta_i;
      meta_o_r  <= meta_r_r;
      meta_m1_r <= meta_o_r;
      meta_m2_r <= meta_m1_r;
    end
  end

  uvp_rotate #(.F(F)) u_rot (
    .clk(clk), .rst_n(rst_n), .en(en), .cs(cfg.uv_rot),
    .meta_i(meta_m2_r), .u_i(u2_r), .v_i(v2_r),
    .meta_o(meta_o), .u_o(u_o), .v_o(v_o)
  );
endmodule

// ----- bench/tb_uv_placement_transform.sv -----
// testbench for uv_placement_transform: random and directed coordinate pairs, checked
// against a fixed-point placement predictor held in a small scoreboard class
// depends on uvp_pkg, the uvp interfaces and the uv_placement_transform rtl
module tb_uv_placement_transform;
  timeunit 1ns;
  timeprecision 1ps;
  import uvp_pkg::*;

  localparam int  FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint HALF = 64'sd1 << (FRAC - 1);
  localparam int  MODE_WRAP_V = 3;
  localparam int  DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic               oof;
  } placed_t;

  class placement_scoreboard;
    logic [63:0] coverage, translate, frame_rot, rep, offset, uv_rot;
    logic [4:0]  mode;
    placed_t     pending[$];
    int          mismatches;

    function new();
      coverage = {32'h0001_0000, 32'h0001_0000};
      translate = '0;
      frame_rot = 64'h0000_0000_0001_0000;
      rep = {32'h0001_0000, 32'h0001_0000};
      offset = '0;
      uv_rot = 64'h0000_0000_0001_0000;
      mode = 5'd12;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] d);
      case (idx)
        REG_COVERAGE:  coverage = d;
        REG_TRANSLATE: translate = d;
        REG_FRAME_ROT: frame_rot = d;
        REG_REPEAT:    rep = d;
        REG_OFFSET:    offset = d;
        REG_UV_ROT:    uv_rot = d;
        REG_MODE:      mode = d[4:0];
        default: ;
      endcase
    endfunction

    function longint lo(logic [63:0] x);
      return longint'($signed(x[31:0]));
    endfunction

    function longint hi(logic [63:0] x);
      return longint'($signed(x[63:32]));
    endfunction

    function longint clip(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint fmul(longint a, longint b);
      return (a * b) >>> FRAC;
    endfunction

    function longint frac_of(longint x);
      return x & (ONE - 1);
    endfunction

    function longint mirror(longint x);
      return clip(2 * (x - frac_of(x)) + ONE - x);
    endfunction

    function longint fdiv(longint n, longint d);
      longint num, q;
      num = n * ONE;
      q = num / d;
      if ((num % d) != 0 && ((num < 0) != (d < 0))) q--;
      return clip(q);
    endfunction

    function void rotate(logic [63:0] cs, inout longint u, inout longint v);
      longint c, s, x, y, nu, nv;
      c = lo(cs);
      s = hi(cs);
      x = u - HALF;
      y = v - HALF;
      nu = HALF + fmul(c, x) - fmul(s, y);
      nv = HALF + fmul(c, y) + fmul(s, x);
      u = clip(nu);
      v = clip(nv);
    endfunction

    function placed_t place(logic signed [31:0] ui, logic signed [31:0] vi);
      placed_t r;
      longint u, v, cu, cv;
      bit outside;
      u = longint'(ui);
      v = longint'(vi);
      cu = lo(coverage);
      cv = hi(coverage);
      rotate(frame_rot, u, v);
      u = clip(u - lo(translate));
      v = clip(v - hi(translate));
      outside = frac_of(u) > cu || frac_of(v) > cv ||
                (!mode[MODE_WRAP_U] && (u < 0 || u > ONE)) ||
                (!mode[MODE_WRAP_V] && (v < 0 || v > ONE)) || cu == 0 || cv == 0;
      if (outside) begin
        r.u = 32'h8000_0000;
        r.v = 32'h8000_0000;
        r.oof = 1'b1;
        return r;
      end
      if (cu < ONE) u = frac_of(u);
      if (cv < ONE) v = frac_of(v);
      u = fdiv(u, cu);
      v = fdiv(v, cv);
      u = clip(fmul(u, lo(rep)));
      v = clip(fmul(v, hi(rep)));
      u = clip(u + lo(offset));
      v = clip(v + hi(offset));
      if ((v & ONE) != 0) begin
        if (mode[MODE_STAGGER]) u = clip(u + HALF);
        if (mode[MODE_MIR_V]) v = mirror(v);
      end
      if (mode[MODE_MIR_U] && (u & ONE) != 0) u = mirror(u);
      rotate(uv_rot, u, v);
      r.u = u[31:0];
      r.v = v[31:0];
      r.oof = 1'b0;
      return r;
    endfunction

    function void note_input(logic signed [31:0] u, logic signed [31:0] v);
      pending.push_back(place(u, v));
    endfunction

    function void check_result(logic signed [31:0] u, logic signed [31:0] v, logic oof);
      placed_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction u=%h v=%h oof=%b", u, v, oof);
        return;
      end
      e = pending.pop_front();
      if (u !== e.u || v !== e.v || oof !== e.oof) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected u=%h v=%h oof=%b, got u=%h v=%h oof=%b",
                   e.u, e.v, e.oof, u, v, oof);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  uvp_in_if  in_ch();
  uvp_out_if out_ch();
  uvp_cfg_if cfg_ch();

  uv_placement_transform dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  placement_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("uv_placement_transform test failed");
    $finish;
  end

  // receiver: checks each result transaction and drives ready
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.u_out, out_ch.v_out, out_ch.out_of_frame);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_pair(logic signed [31:0] u, logic signed [31:0] v);
    in_ch.valid <= 1'b1;
    in_ch.u_in <= u;
    in_ch.v_in <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(u, v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] small_fx();
    return 32'($urandom_range(0, 4 * 65536)) - 32'd98304;
  endfunction

  function automatic logic [31:0] angle_half();
    case ($urandom_range(5))
      0: return 32'h0001_0000;
      1: return 32'h0000_0000;
      2: return 32'hFFFF_0000;
      3: return 32'h0000_B505;
      4: return 32'hFFFF_4AFB;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] coverage_half();
    case ($urandom_range(5))
      0: return 32'h0001_0000;
      1: return 32'($urandom_range(1, 65535));
      2: return 32'h0000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(65536, 4 * 65536));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3, 4, 5, 6: return small_fx();
      default: return $urandom;
    endcase
  endfunction

  task automatic configure(int phase);
    if (phase == 8) begin
      write_reg(REG_COVERAGE, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_FRAME_ROT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_REPEAT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_UV_ROT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_MODE, 64'd31);
    end else if (phase == 7) begin
      write_reg(REG_COVERAGE, 64'h7FFF_FFFF_7FFF_FFFF);
      write_reg(REG_TRANSLATE, 64'h8000_0000_7FFF_FFFF);
      write_reg(REG_FRAME_ROT, {$urandom, $urandom});
      write_reg(REG_REPEAT, 64'h7FFF_FFFF_8000_0000);
      write_reg(REG_OFFSET, {$urandom, $urandom});
      write_reg(REG_UV_ROT, {$urandom, $urandom});
      write_reg(REG_MODE, 64'd0);
    end else begin
      write_reg(REG_COVERAGE, {coverage_half(), coverage_half()});
      write_reg(REG_TRANSLATE, {small_fx() >>> 1, small_fx() >>> 1});
      write_reg(REG_FRAME_ROT, {angle_half(), angle_half()});
      write_reg(REG_REPEAT, {small_fx() + 32'h0002_0000, small_fx() + 32'h0002_0000});
      write_reg(REG_OFFSET, {small_fx(), small_fx()});
      write_reg(REG_UV_ROT, {angle_half(), angle_half()});
      write_reg(REG_MODE, 64'($urandom_range(31)));
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 37;
    recv_idle_pct = 47;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.u_in = '0;
    in_ch.v_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_COVERAGE;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs at reset settings
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0001_0000, 32'h0001_0000);
    send_pair(32'h0000_8000, 32'h0000_8000);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'hFFFF_0000, 32'h0000_4000);
    send_pair(32'h0001_8000, 32'h0000_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h5555_5555);
    send_pair(32'hAAAA_AAAA, 32'hFFFF_FFFF);
    drain();
    // mirrors, stagger, half coverage and no wrap
    write_reg(REG_MODE, 64'd19);
    write_reg(REG_COVERAGE, {32'h0000_8000, 32'h0001_0000});
    send_pair(32'h0000_4000, 32'h0000_4000);
    send_pair(32'h0001_4000, 32'h0001_4000);
    send_pair(32'hFFFF_C000, 32'h0000_2000);
    send_pair(32'h0000_C000, 32'h0000_C000);
    drain();
    write_reg(REG_COVERAGE, {32'h0000_0000, 32'h0001_0000});
    send_pair(32'h0000_4000, 32'h0000_4000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      if (phase >= 3 && phase < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 37;
      end else if (phase >= 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(phase);
      if (phase == 4) hold_cycles = 300;
      for (int i = 0; i < 183; i++) begin
        if (phase >= 7 || $urandom_range(3) == 0)
          send_pair(rand_coord(), rand_coord());
        else
          send_pair(32'($urandom_range(0, 65536)), 32'($urandom_range(0, 65536)));
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("uv_placement_transform test passed");
    else
      $display("uv_placement_transform test failed");
    $finish;
  end
endmodule
